// ===== src/nmp_pkg.sv =====
// ----------------------------------------------------------------------------
// nmp_pkg
// shared types, widths, register codes and helpers of the n-d max pooling block
// ----------------------------------------------------------------------------
package nmp_pkg;

	localparam int SAMPLE_BITS     = 16;
	localparam int ADDR_BITS       = 16;
	localparam int EXT_BITS        = 16;
	localparam int EXT_W           = EXT_BITS + 1;
	localparam int FIELD_DIMS      = 4;
	localparam int DIM_BITS        = 2;
	localparam int RANK_BITS       = 3;
	localparam int TILE_BITS       = 4;
	localparam int POOL_BITS       = 4;
	localparam int COUNT_W         = 2 * ADDR_BITS + 1;
	localparam int BASE_W          = ADDR_BITS + TILE_BITS;
	localparam int IX_W            = BASE_W + 1;
	localparam int CFG_INDEX_BITS  = 3;
	localparam int CFG_DATA_BITS   = FIELD_DIMS * EXT_BITS;

	localparam int DEF_MAX_RANK    = 4;
	localparam int DEF_STORE_DEPTH = 65536;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_RANK       = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_TILE_STEP  = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_POOL_WIDTH = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_IN_EXT     = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_OUT_EXT    = 3'd4;

	localparam logic [RANK_BITS-1:0]     RANK_RST    = 3'd2;
	localparam logic [TILE_BITS-1:0]     TILE_RST    = 4'd2;
	localparam logic [POOL_BITS-1:0]     POOL_RST    = 4'd2;
	localparam logic [CFG_DATA_BITS-1:0] IN_EXT_RST  = 64'd16711935;
	localparam logic [CFG_DATA_BITS-1:0] OUT_EXT_RST = 64'd8323199;

	localparam logic KIND_LOAD    = 1'b0;
	localparam logic KIND_REQUEST = 1'b1;

	localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic [COUNT_W-1:0] COUNT_CAP =
		{{(COUNT_W-ADDR_BITS-1){1'b0}}, 1'b1, {ADDR_BITS{1'b0}}};

	typedef struct packed {
		logic                          kind;
		logic [ADDR_BITS-1:0]          address;
		logic signed [SAMPLE_BITS-1:0] sample;
	} item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] max_value;
		logic                          window_empty;
		logic                          request_error;
	} result_t;

	// extent of one dimension from a packed extents register
	function automatic logic [EXT_W-1:0] ext_of(input logic [CFG_DATA_BITS-1:0] ext,
		input logic [DIM_BITS-1:0] dim);
		return EXT_W'(ext[EXT_BITS*dim +: EXT_BITS]) + EXT_W'(1);
	endfunction

endpackage

// ===== src/nd_max_pool_top.sv =====
// ----------------------------------------------------------------------------
// nd_max_pool_top
// max pooling over an n-d sample array held in an on-chip store
// ----------------------------------------------------------------------------
// item channel (item_valid/item_stall/item): a load transaction writes one
// sample at a linear address; a request transaction names a linear output
// position. result channel (result_valid/result_stall/result): one result per
// request, none per load. the config port writes rank, tile step, pool width
// and the packed extents; write it only while the block is idle.
// a load with a power-of-two store depth is written to the store as it is
// accepted; otherwise the address is first reduced by the serial divider.
// a request takes one multiply per dimension for the output count, one
// 16-step serial division per dimension for the output index, then up to
// one multiply-add per dimension per window cell on the shared multiplier,
// with one store read per in-range cell. with a store depth that is not a
// power of two each multiply-add also waits for a serial reduction.
// item_stall is high while a request or reduced load is in progress. a
// finished result sits in the output register until taken; the next item is
// accepted meanwhile, and a following request waits for the register.
// reset restores the register defaults and empties the output register; the
// store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module nd_max_pool_top import nmp_pkg::*; #(
	parameter int MAX_RANK    = DEF_MAX_RANK,
	parameter int STORE_DEPTH = DEF_STORE_DEPTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_stall,
	input  item_t                     item,
	output logic                      result_valid,
	input  logic                      result_stall,
	output result_t                   result,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int LIM  = (MAX_RANK < FIELD_DIMS) ? MAX_RANK : FIELD_DIMS;
	localparam int CNTW = $clog2(LIM + 1);
	localparam int IW   = (LIM > 1) ? $clog2(LIM) : 1;
	localparam int AW   = $clog2(STORE_DEPTH);
	localparam bit POW2 = (STORE_DEPTH == (1 << AW));
	localparam int MA   = (AW > EXT_W) ? AW : EXT_W;
	localparam int PRW  = MA + EXT_W;
	localparam int PW   = PRW + 1;
	localparam int DB   = (EXT_W > AW + 1) ? EXT_W : AW + 1;
	localparam int DCW  = $clog2(PW);
	localparam int XW   = (AW > ADDR_BITS) ? AW : ADDR_BITS;

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_LDIV   = 9'b000000010,
		ST_COUNT  = 9'b000000100,
		ST_DSTART = 9'b000001000,
		ST_DWAIT  = 9'b000010000,
		ST_SCAN   = 9'b000100000,
		ST_REDUCE = 9'b001000000,
		ST_FINISH = 9'b010000000,
		ST_DONE   = 9'b100000000
	} state_t;

	state_t                         state_q;
	logic [RANK_BITS-1:0]           rank_q;
	logic [TILE_BITS-1:0]           tile_q;
	logic [POOL_BITS-1:0]           pool_q;
	logic [CFG_DATA_BITS-1:0]       in_ext_q;
	logic [CFG_DATA_BITS-1:0]       out_ext_q;
	logic                           out_valid_q;
	logic                           rd_pend_q;
	result_t                        out_q;
	logic [ADDR_BITS-1:0]           addr_q;
	logic signed [SAMPLE_BITS-1:0]  sample_q;
	logic [COUNT_W-1:0]             count_q;
	logic [CNTW-1:0]                d_q;
	logic [IW-1:0]                  k_q;
	logic [BASE_W-1:0]              base_q [LIM];
	logic [POOL_BITS-1:0]           pidx_q [LIM];
	logic [AW-1:0]                  pos_q;
	logic signed [SAMPLE_BITS-1:0]  best_q;
	logic                           any_q;
	logic                           err_q;

	logic                           item_acc;
	logic                           out_free;
	logic [RANK_BITS-1:0]           rank_c;
	logic [CNTW-1:0]                live_r;
	logic [IW-1:0]                  k_top;
	logic [IW-1:0]                  d_idx;
	logic [EXT_W-1:0]               e_out_d;
	logic [EXT_W-1:0]               e_in_k;
	logic [IX_W-1:0]                ix;
	logic                           outside;
	logic [MA-1:0]                  mul_a;
	logic [EXT_W-1:0]               mul_b;
	logic [PRW-1:0]                 prod;
	logic [PW-1:0]                  sum;
	logic                           count_end;
	logic                           count_err;
	logic                           split_last;
	logic [POOL_BITS-1:0]           pidx_nx [LIM];
	logic                           odo_done;
	logic                           step_ok;
	logic                           step_last;
	logic                           step_mid;
	logic                           cell_next;
	logic [AW-1:0]                  pos_new;
	logic                           div_start;
	logic [PW-1:0]                  div_num;
	logic [DCW-1:0]                 div_msb;
	logic [DB-1:0]                  div_den;
	logic                           div_done;
	logic [PW-1:0]                  div_quot;
	logic [DB-1:0]                  div_rem;
	logic                           ram_we;
	logic [AW-1:0]                  ram_waddr;
	logic [SAMPLE_BITS-1:0]         ram_wdata;
	logic [SAMPLE_BITS-1:0]         ram_rdata;
	logic [XW-1:0]                  addr_ext;
	logic                           load_now;

	assign item_stall = (state_q != ST_IDLE);
	assign item_acc   = item_valid && !item_stall;
	assign out_free   = !out_valid_q || !result_stall;
	assign addr_ext   = XW'(item.address);
	assign load_now   = item_acc && (item.kind == KIND_LOAD);

	always_comb begin
		rank_c = rank_q;
		if (rank_c == '0) begin
			rank_c = RANK_BITS'(1);
		end
		if (rank_c > RANK_BITS'(LIM)) begin
			rank_c = RANK_BITS'(LIM);
		end
	end

	assign live_r  = CNTW'(rank_c);
	assign k_top   = IW'(live_r - CNTW'(1));
	assign d_idx   = d_q[IW-1:0];
	assign e_out_d = ext_of(out_ext_q, DIM_BITS'(d_idx));
	assign e_in_k  = ext_of(in_ext_q, DIM_BITS'(k_q));
	assign ix      = IX_W'(base_q[k_q]) + IX_W'(pidx_q[k_q]);
	assign outside = ix >= IX_W'(e_in_k);

	assign count_end  = !((d_q < live_r) && (count_q <= COUNT_CAP));
	assign count_err  = COUNT_W'(addr_q) >= count_q;
	assign split_last = !((d_q + CNTW'(1)) < live_r);

	// shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_COUNT: begin
				mul_a = MA'(count_q[ADDR_BITS:0]);
				mul_b = e_out_d;
			end
			ST_DWAIT: begin
				mul_a = MA'(div_rem[ADDR_BITS-1:0]);
				mul_b = EXT_W'(tile_q);
			end
			ST_SCAN: begin
				mul_a = MA'(pos_q);
				mul_b = e_in_k;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = {{EXT_W{1'b0}}, mul_a} * {{MA{1'b0}}, mul_b};
	assign sum  = PW'(prod) + PW'(ix);

	// window odometer, dimension 0 fastest
	always_comb begin
		logic                 carry;
		logic [POOL_BITS:0]   p;
		carry = 1'b1;
		p     = '0;
		for (int i = 0; i < LIM; i++) begin
			pidx_nx[i] = pidx_q[i];
			if ((CNTW'(i) < live_r) && carry) begin
				p = {1'b0, pidx_q[i]} + (POOL_BITS+1)'(1);
				if (p < {1'b0, pool_q}) begin
					pidx_nx[i] = p[POOL_BITS-1:0];
					carry      = 1'b0;
				end else begin
					pidx_nx[i] = '0;
				end
			end
		end
		odo_done = carry;
	end

	assign step_ok   = ((state_q == ST_SCAN) && !outside && POW2) ||
		((state_q == ST_REDUCE) && div_done);
	assign step_last = step_ok && (k_q == '0);
	assign step_mid  = step_ok && (k_q != '0);
	assign cell_next = ((state_q == ST_SCAN) && outside) || step_last;
	assign pos_new   = POW2 ? sum[AW-1:0] : div_rem[AW-1:0];

	// serial divider: output index split and store address reduction
	assign div_start = (load_now && !POW2) || (state_q == ST_DSTART) ||
		((state_q == ST_SCAN) && !outside && !POW2);

	always_comb begin
		case (state_q)
			ST_IDLE: begin
				div_num = PW'(item.address);
				div_msb = DCW'(ADDR_BITS - 1);
				div_den = DB'(STORE_DEPTH);
			end
			ST_DSTART: begin
				div_num = PW'(addr_q);
				div_msb = DCW'(ADDR_BITS - 1);
				div_den = DB'(e_out_d);
			end
			default: begin
				div_num = sum;
				div_msb = DCW'(PW - 1);
				div_den = DB'(STORE_DEPTH);
			end
		endcase
	end

	nmp_div #(
		.NUM_BITS (PW),
		.DEN_BITS (DB)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.msb    (div_msb),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot),
		.rem    (div_rem)
	);

	assign ram_we    = (load_now && POW2) || ((state_q == ST_LDIV) && div_done);
	assign ram_waddr = (state_q == ST_LDIV) ? div_rem[AW-1:0] : addr_ext[AW-1:0];
	assign ram_wdata = (state_q == ST_LDIV) ? sample_q : item.sample;

	nmp_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (step_last),
		.raddr (pos_new),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rank_q      <= RANK_RST;
			tile_q      <= TILE_RST;
			pool_q      <= POOL_RST;
			in_ext_q    <= IN_EXT_RST;
			out_ext_q   <= OUT_EXT_RST;
			out_valid_q <= 1'b0;
			rd_pend_q   <= 1'b0;
		end else begin
			rd_pend_q <= step_last;

			if (cfg_we) begin
				case (cfg_index)
					CFG_RANK:       rank_q    <= cfg_data[RANK_BITS-1:0];
					CFG_TILE_STEP:  tile_q    <= cfg_data[TILE_BITS-1:0];
					CFG_POOL_WIDTH: pool_q    <= cfg_data[POOL_BITS-1:0];
					CFG_IN_EXT:     in_ext_q  <= cfg_data;
					CFG_OUT_EXT:    out_ext_q <= cfg_data;
					default: ;
				endcase
			end

			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (item_acc && (item.kind == KIND_REQUEST)) begin
						state_q <= ST_COUNT;
					end else if (load_now && !POW2) begin
						state_q <= ST_LDIV;
					end
				end
				ST_LDIV: begin
					if (div_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_COUNT: begin
					if (count_end) begin
						state_q <= count_err ? ST_DONE : ST_DSTART;
					end
				end
				ST_DSTART: begin
					state_q <= ST_DWAIT;
				end
				ST_DWAIT: begin
					if (div_done) begin
						if (!split_last) begin
							state_q <= ST_DSTART;
						end else if (pool_q == '0) begin
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (cell_next && odo_done) begin
						state_q <= ST_FINISH;
					end else if (!outside && !POW2) begin
						state_q <= ST_REDUCE;
					end
				end
				ST_REDUCE: begin
					if (div_done) begin
						state_q <= (step_last && odo_done) ? ST_FINISH : ST_SCAN;
					end
				end
				ST_FINISH: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pend_q) begin
			any_q <= 1'b1;
			if (!any_q || ($signed(ram_rdata) > best_q)) begin
				best_q <= $signed(ram_rdata);
			end
		end

		case (state_q)
			ST_IDLE: begin
				if (item_acc) begin
					addr_q   <= item.address;
					sample_q <= item.sample;
					count_q  <= COUNT_W'(1);
					d_q      <= '0;
					err_q    <= 1'b0;
					any_q    <= 1'b0;
					best_q   <= MOST_NEG;
				end
			end
			ST_COUNT: begin
				if (!count_end) begin
					count_q <= prod[COUNT_W-1:0];
					d_q     <= d_q + CNTW'(1);
				end else if (count_err) begin
					err_q <= 1'b1;
				end else begin
					d_q <= '0;
				end
			end
			ST_DWAIT: begin
				if (div_done) begin
					base_q[d_idx] <= prod[BASE_W-1:0];
					addr_q        <= div_quot[ADDR_BITS-1:0];
					d_q           <= d_q + CNTW'(1);
					if (split_last) begin
						pidx_q <= '{default: '0};
						k_q    <= k_top;
						pos_q  <= '0;
					end
				end
			end
			ST_SCAN, ST_REDUCE: begin
				if (cell_next) begin
					pidx_q <= pidx_nx;
					k_q    <= k_top;
					pos_q  <= '0;
				end else if (step_mid) begin
					k_q   <= k_q - IW'(1);
					pos_q <= pos_new;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					if (err_q) begin
						out_q.max_value     <= '0;
						out_q.window_empty  <= 1'b0;
						out_q.request_error <= 1'b1;
					end else begin
						out_q.max_value     <= best_q;
						out_q.window_empty  <= !any_q;
						out_q.request_error <= 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

`ifndef SYNTH
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the done state");

	a_read_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |-> ($past(state_q) == ST_SCAN || $past(state_q) == ST_REDUCE))
		else $error("store read pending without a window step");

	a_dim_in_rank: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (CNTW'(k_q) < live_r))
		else $error("window dimension counter beyond rank");

	a_empty_value: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.window_empty) |->
		(result.max_value == MOST_NEG && !result.request_error))
		else $error("empty window with wrong value");

	a_error_value: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.request_error) |->
		(result.max_value == '0 && !result.window_empty))
		else $error("request error with wrong fields");
`endif

endmodule

// ===== src/nmp_ram.sv =====
// ----------------------------------------------------------------------------
// nmp_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module nmp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/nmp_div.sv =====
// ----------------------------------------------------------------------------
// nmp_div
// iterative restoring divider, one dividend bit per cycle from a chosen msb
// ----------------------------------------------------------------------------
module nmp_div #(
	parameter int NUM_BITS = 35,
	parameter int DEN_BITS = 17
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [NUM_BITS-1:0]         num,
	input  logic [$clog2(NUM_BITS)-1:0] msb,
	input  logic [DEN_BITS-1:0]         den,
	output logic                        done,
	output logic [NUM_BITS-1:0]         quot,
	output logic [DEN_BITS-1:0]         rem
);

	localparam int CW = $clog2(NUM_BITS);

	logic                active_q;
	logic                done_q;
	logic [NUM_BITS-1:0] num_q;
	logic [DEN_BITS-1:0] den_q;
	logic [CW-1:0]       cnt_q;
	logic [DEN_BITS-1:0] rem_q;
	logic [NUM_BITS-1:0] quot_q;

	logic [DEN_BITS:0]   trial;
	logic [DEN_BITS:0]   diff;
	logic                ge;
	logic [DEN_BITS-1:0] rem_nx;

	assign trial  = {rem_q, num_q[cnt_q]};
	assign diff   = trial - {1'b0, den_q};
	assign ge     = trial >= {1'b0, den_q};
	assign rem_nx = ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= active_q && (cnt_q == '0) && !start;
			if (start) begin
				active_q <= 1'b1;
			end else if (active_q && (cnt_q == '0)) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			den_q  <= den;
			cnt_q  <= msb;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (active_q) begin
			rem_q  <= rem_nx;
			quot_q <= {quot_q[NUM_BITS-2:0], ge};
			cnt_q  <= cnt_q - CW'(1);
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule
